/* rtl/slldc_pkg.sv */
// shared types and constants of the signed line-to-line distance core
`timescale 1ns / 1ps
`default_nettype none

package slldc_pkg;

    localparam int COORD_W   = 32;
    localparam int FRAC_BITS = 16;
    localparam int SLOPE_W   = 24;
    localparam int TRACK_X   = 850;

    // wire direction, track point minus wire end, cross product
    localparam int W_W  = COORD_W + 1;
    localparam int D_W  = 36;
    localparam int P_W  = W_W + SLOPE_W;
    localparam int K_W  = P_W + 1;

    // cross product split into halves for the wide products
    localparam int KL_W = 29;
    localparam int KH_W = K_W - KL_W;
    localparam int NH_W = D_W + KH_W;
    localparam int NL_W = D_W + KL_W + 1;
    localparam int HH_W = 2 * KH_W;
    localparam int HL_W = KH_W + KL_W + 1;
    localparam int LL_W = 2 * KL_W;

    // dot product and squared norm
    localparam int NUM_W  = 97;
    localparam int MAG_W  = NUM_W - 1;
    localparam int SQS_W  = 120;
    localparam int NSQA_W = 2 * K_W - 1;
    localparam int NSQ_W  = NSQA_W + 2;

    // square root and division
    localparam int ROOT_W = (NSQ_W + 1) / 2;
    localparam int SQ_TW  = NSQ_W + 2;
    localparam int REM_W  = ROOT_W + 1;

    localparam logic signed [D_W-1:0] TRACK_X_D  = D_W'(TRACK_X);
    localparam logic signed [D_W-1:0] TRACK_X_Q  = D_W'(TRACK_X * (1 << FRAC_BITS));
    localparam logic [COORD_W:0]      SAT_NEG    = (COORD_W + 1)'(1) << (COORD_W - 1);
    localparam logic [COORD_W:0]      SAT_POS    = SAT_NEG - (COORD_W + 1)'(1);

    typedef struct packed {
        logic signed [SLOPE_W-1:0] track_slope_y;
        logic signed [COORD_W-1:0] track_offset_y;
        logic signed [SLOPE_W-1:0] track_slope_z;
        logic signed [COORD_W-1:0] track_offset_z;
        logic signed [COORD_W-1:0] wire_a_x;
        logic signed [COORD_W-1:0] wire_a_y;
        logic signed [COORD_W-1:0] wire_a_z;
        logic signed [COORD_W-1:0] wire_b_x;
        logic signed [COORD_W-1:0] wire_b_y;
        logic signed [COORD_W-1:0] wire_b_z;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] distance;
        logic                      lines_parallel;
        logic                      saturated;
    } t_out_item;

    // sideband that rides along the root and quotient pipelines
    typedef struct packed {
        logic             neg;
        logic             par;
        logic [MAG_W-1:0] mag;
    } t_side;

endpackage

`default_nettype wire

/* rtl/slldc_sqrt.sv */
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none

module slldc_sqrt
    import slldc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  logic [NSQ_W-1:0]  i_nsq,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [ROOT_W-1:0] o_root,
    output t_side             o_side
);

    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SQ_TW-1:0]  r_rem  [ROOT_W];
    t_side             r_side [ROOT_W];
    logic              r_vld  [ROOT_W];

    genvar i;
    for (i = 0; i < ROOT_W; i++) begin : g_step
        localparam int B = ROOT_W - 1 - i;
        logic [ROOT_W-1:0] c_root;
        logic [SQ_TW-1:0]  c_rem;
        logic [SQ_TW-1:0]  c_trial;
        t_side             c_side;
        logic              c_vld;
        logic [ROOT_W-1:0] n_root;
        logic [SQ_TW-1:0]  n_rem;

        if (i == 0) begin : g_first
            assign c_root = '0;
            assign c_rem  = SQ_TW'(i_nsq);
            assign c_side = i_side;
            assign c_vld  = i_valid;
        end else begin : g_next
            assign c_root = r_root[i-1];
            assign c_rem  = r_rem[i-1];
            assign c_side = r_side[i-1];
            assign c_vld  = r_vld[i-1];
        end

        // (r + 2^b)^2 - r^2
        assign c_trial = (SQ_TW'(c_root) << (B + 1)) + (SQ_TW'(1) << (2 * B));

        always_comb begin
            if (c_rem >= c_trial) begin
                n_root = c_root | (ROOT_W'(1) << B);
                n_rem  = c_rem - c_trial;
            end else begin
                n_root = c_root;
                n_rem  = c_rem;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_ce) begin
                r_vld[i] <= c_vld;
            end
            if (i_ce) begin
                r_root[i] <= n_root;
                r_rem[i]  <= n_rem;
                r_side[i] <= c_side;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];

endmodule

`default_nettype wire

/* rtl/slldc_div.sv */
// pipelined rounded division, saturation and sign of the distance
`timescale 1ns / 1ps
`default_nettype none

module slldc_div
    import slldc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  logic [ROOT_W-1:0] i_root,
    input  t_side             i_side,
    output logic              o_valid,
    output t_out_item         o_item
);

    // pre stage: overflow check and first partial remainder
    logic               r_p_vld;
    logic               r_p_ovf;
    logic [REM_W-1:0]   r_p_rem;
    logic [COORD_W-1:0] r_p_low;
    logic [ROOT_W-1:0]  r_p_den;
    logic               r_p_neg;
    logic               r_p_par;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_ce) begin
            r_p_vld <= i_valid;
        end
        if (i_ce) begin
            r_p_ovf <= i_side.mag >= (MAG_W'(i_root) << COORD_W);
            r_p_rem <= i_side.mag[COORD_W+REM_W-1:COORD_W];
            r_p_low <= i_side.mag[COORD_W-1:0];
            r_p_den <= i_root;
            r_p_neg <= i_side.neg;
            r_p_par <= i_side.par;
        end
    end

    logic               r_vld [COORD_W];
    logic               r_ovf [COORD_W];
    logic [REM_W-1:0]   r_rem [COORD_W];
    logic [COORD_W-1:0] r_low [COORD_W];
    logic [COORD_W-1:0] r_quo [COORD_W];
    logic [ROOT_W-1:0]  r_den [COORD_W];
    logic               r_neg [COORD_W];
    logic               r_par [COORD_W];

    genvar j;
    for (j = 0; j < COORD_W; j++) begin : g_step
        logic               c_vld;
        logic               c_ovf;
        logic [REM_W-1:0]   c_rem;
        logic [COORD_W-1:0] c_low;
        logic [COORD_W-1:0] c_quo;
        logic [ROOT_W-1:0]  c_den;
        logic               c_neg;
        logic               c_par;
        logic [REM_W-1:0]   c_shift;
        logic [REM_W-1:0]   n_rem;
        logic [COORD_W-1:0] n_quo;

        if (j == 0) begin : g_first
            assign c_vld = r_p_vld;
            assign c_ovf = r_p_ovf;
            assign c_rem = r_p_rem;
            assign c_low = r_p_low;
            assign c_quo = '0;
            assign c_den = r_p_den;
            assign c_neg = r_p_neg;
            assign c_par = r_p_par;
        end else begin : g_next
            assign c_vld = r_vld[j-1];
            assign c_ovf = r_ovf[j-1];
            assign c_rem = r_rem[j-1];
            assign c_low = r_low[j-1];
            assign c_quo = r_quo[j-1];
            assign c_den = r_den[j-1];
            assign c_neg = r_neg[j-1];
            assign c_par = r_par[j-1];
        end

        assign c_shift = {c_rem[REM_W-2:0], c_low[COORD_W-1]};

        always_comb begin
            if (c_shift >= REM_W'(c_den)) begin
                n_rem = c_shift - REM_W'(c_den);
                n_quo = {c_quo[COORD_W-2:0], 1'b1};
            end else begin
                n_rem = c_shift;
                n_quo = {c_quo[COORD_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_ce) begin
                r_vld[j] <= c_vld;
            end
            if (i_ce) begin
                r_ovf[j] <= c_ovf;
                r_rem[j] <= n_rem;
                r_low[j] <= {c_low[COORD_W-2:0], 1'b0};
                r_quo[j] <= n_quo;
                r_den[j] <= c_den;
                r_neg[j] <= c_neg;
                r_par[j] <= c_par;
            end
        end
    end

    // round half up on the magnitude, then clip and apply the sign
    logic               c_rnd;
    logic [COORD_W:0]   c_q;
    logic [COORD_W:0]   c_top;
    logic               c_sat;
    logic [COORD_W-1:0] c_mag;
    t_out_item          n_item;
    logic               r_out_vld;
    t_out_item          r_item;

    always_comb begin
        c_rnd = {r_rem[COORD_W-1], 1'b0} >= (REM_W + 1)'(r_den[COORD_W-1]);
        c_q   = {1'b0, r_quo[COORD_W-1]} + (COORD_W + 1)'(c_rnd);
        c_top = r_neg[COORD_W-1] ? SAT_NEG : SAT_POS;
        c_sat = r_ovf[COORD_W-1] || (c_q > c_top);
        c_mag = c_sat ? c_top[COORD_W-1:0] : c_q[COORD_W-1:0];
        if (r_par[COORD_W-1]) begin
            n_item.distance       = '0;
            n_item.lines_parallel = 1'b1;
            n_item.saturated      = 1'b0;
        end else begin
            n_item.distance       = r_neg[COORD_W-1] ? -c_mag : c_mag;
            n_item.lines_parallel = 1'b0;
            n_item.saturated      = c_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_ce) begin
            r_out_vld <= r_vld[COORD_W-1];
        end
        if (i_ce) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_out_vld;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* rtl/signed_line_to_line_distance_core.sv */
// top level of the signed track-to-wire distance pipeline
`timescale 1ns / 1ps
`default_nettype none

// signed shortest distance between a straight track (y and z as slope and
// intercept over x, slopes q8.16, intercepts q16.16) and a sense wire given by
// its end points a and b (q16.16). the track point is taken at x = +850, the
// result is (p - a) . (w x v) / |w x v| with w = a - b and v = (1, my, mz),
// rounded to nearest with ties away from zero and clipped to the 32-bit range.
// parallel or degenerate lines give distance 0 with lines_parallel set.
// one transaction is accepted every cycle unless the output holds; there are 8 front-end
// stages, 59 square-root stages (one root bit each), one overflow check stage, 32 quotient
// stages (one bit each) and the output register.
// the whole pipeline holds while a finished result is stalled at the output,
// so o_stall follows i_stall only while o_valid is high.

module signed_line_to_line_distance_core
    import slldc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_item
);

    // global advance: everything moves unless the output is held
    logic ce;
    assign ce      = !(o_valid && i_stall);
    assign o_stall = !ce;

    logic [8:1] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[7:1], i_valid};
        end
    end

    // stage 1: input register
    t_in_item r_in;

    // stage 2: wire direction and track point minus wire end a
    logic signed [W_W-1:0]     r_w [3];
    logic signed [D_W-1:0]     r_d2 [3];
    logic signed [SLOPE_W-1:0] r_my;
    logic signed [SLOPE_W-1:0] r_mz;

    // stage 3: slope products of the cross product
    logic signed [P_W-1:0] r_pyz;
    logic signed [P_W-1:0] r_pzy;
    logic signed [P_W-1:0] r_pxz;
    logic signed [P_W-1:0] r_pxy;
    logic signed [W_W-1:0] r_w3 [3];
    logic signed [D_W-1:0] r_d3 [3];

    // stage 4: cross product c = w x v
    logic signed [K_W-1:0] r_k [3];
    logic signed [D_W-1:0] r_d4 [3];

    // stage 5: partial products of d.c and |c|^2 per axis
    logic signed [NH_W-1:0] r_nh [3];
    logic signed [NL_W-1:0] r_nl [3];
    logic signed [HH_W-1:0] r_hh [3];
    logic signed [HL_W-1:0] r_hl [3];
    logic [LL_W-1:0]        r_ll [3];

    // stage 6: per-axis terms
    logic signed [NUM_W-1:0] r_na [3];
    logic [NSQA_W-1:0]       r_sa [3];

    // stage 7: sums
    logic signed [NUM_W-1:0] r_num;
    logic [NSQ_W-1:0]        r_nsq;

    // stage 8: magnitude, sign and parallel flag
    t_side            r_side;
    logic [NSQ_W-1:0] r_nsq8;

    logic signed [D_W-1:0] n_d [3];
    logic signed [W_W-1:0] n_w [3];
    logic signed [K_W-1:0] n_k [3];
    logic signed [SQS_W-1:0] c_sq [3];
    logic signed [NUM_W-1:0] c_negnum;

    always_comb begin
        n_w[0] = W_W'(r_in.wire_a_x) - W_W'(r_in.wire_b_x);
        n_w[1] = W_W'(r_in.wire_a_y) - W_W'(r_in.wire_b_y);
        n_w[2] = W_W'(r_in.wire_a_z) - W_W'(r_in.wire_b_z);
        n_d[0] = TRACK_X_Q - D_W'(r_in.wire_a_x);
        n_d[1] = D_W'(r_in.track_slope_y) * TRACK_X_D + D_W'(r_in.track_offset_y)
                 - D_W'(r_in.wire_a_y);
        n_d[2] = D_W'(r_in.track_slope_z) * TRACK_X_D + D_W'(r_in.track_offset_z)
                 - D_W'(r_in.wire_a_z);

        // v = (1, my, mz) with 1 as a shift by the fraction width
        n_k[0] = K_W'(r_pyz) - K_W'(r_pzy);
        n_k[1] = (K_W'(r_w3[2]) <<< FRAC_BITS) - K_W'(r_pxz);
        n_k[2] = K_W'(r_pxy) - (K_W'(r_w3[1]) <<< FRAC_BITS);

        for (int a = 0; a < 3; a++) begin
            c_sq[a] = (SQS_W'(r_hh[a]) <<< (2 * KL_W)) + (SQS_W'(r_hl[a]) <<< (KL_W + 1))
                      + SQS_W'({1'b0, r_ll[a]});
        end

        c_negnum = -r_num;
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_in <= i_item;

            r_w  <= n_w;
            r_d2 <= n_d;
            r_my <= r_in.track_slope_y;
            r_mz <= r_in.track_slope_z;

            r_pyz <= P_W'(r_w[1]) * P_W'(r_mz);
            r_pzy <= P_W'(r_w[2]) * P_W'(r_my);
            r_pxz <= P_W'(r_w[0]) * P_W'(r_mz);
            r_pxy <= P_W'(r_w[0]) * P_W'(r_my);
            r_w3  <= r_w;
            r_d3  <= r_d2;

            r_k  <= n_k;
            r_d4 <= r_d3;

            for (int a = 0; a < 3; a++) begin
                r_nh[a] <= NH_W'(r_d4[a]) * NH_W'($signed(r_k[a][K_W-1:KL_W]));
                r_nl[a] <= NL_W'(r_d4[a]) * NL_W'($signed({1'b0, r_k[a][KL_W-1:0]}));
                r_hh[a] <= HH_W'($signed(r_k[a][K_W-1:KL_W]))
                           * HH_W'($signed(r_k[a][K_W-1:KL_W]));
                r_hl[a] <= HL_W'($signed(r_k[a][K_W-1:KL_W]))
                           * HL_W'($signed({1'b0, r_k[a][KL_W-1:0]}));
                r_ll[a] <= LL_W'(r_k[a][KL_W-1:0]) * LL_W'(r_k[a][KL_W-1:0]);

                r_na[a] <= (NUM_W'(r_nh[a]) <<< KL_W) + NUM_W'(r_nl[a]);
                r_sa[a] <= c_sq[a][NSQA_W-1:0];
            end

            r_num <= r_na[0] + r_na[1] + r_na[2];
            r_nsq <= NSQ_W'(r_sa[0]) + NSQ_W'(r_sa[1]) + NSQ_W'(r_sa[2]);

            r_side.neg <= r_num[NUM_W-1];
            r_side.par <= (r_nsq == '0);
            r_side.mag <= r_num[NUM_W-1] ? c_negnum[MAG_W-1:0] : r_num[MAG_W-1:0];
            r_nsq8     <= r_nsq;
        end
    end

    // square root of |c|^2
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    t_side             sq_side;

    slldc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (r_vld[8]),
        .i_nsq   (r_nsq8),
        .i_side  (r_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // quotient, rounding, clipping and output register
    slldc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (sq_valid),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

`ifndef SYNTHESIS
    // a parallel result carries no distance and no clip
    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.lines_parallel |-> o_item.distance == '0 && !o_item.saturated)
        else $error("parallel result with nonzero distance or clip");

    // a clipped distance sits at one end of the range
    a_sat_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.saturated |->
            o_item.distance == SAT_POS[COORD_W-1:0] || o_item.distance == SAT_NEG[COORD_W-1:0])
        else $error("saturated distance not at a range end");

    // input back-pressure only while an output transaction is held
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall out of step with output hold");

    // a held output transaction does not move
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("held output changed");
`endif

endmodule

`default_nettype wire

/* tb/signed_line_to_line_distance_core_test.sv */
// testbench for the signed track-to-wire distance core
`timescale 1ns / 1ps

module signed_line_to_line_distance_core_test;
    import slldc_pkg::*;

    localparam int N_RANDOM    = 730;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 120;     // a little more than the pipeline latency
    localparam int HOLD_AT     = 300;     // long receiver hold starts here
    localparam int HOLD_LEN    = 300;
    localparam int PAUSE_AT    = 520;     // sender waits for the pipeline to drain here

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_item  i_item = '0;
    logic      i_stall = 1'b0;
    logic      o_stall;
    logic      o_valid;
    t_out_item o_item;

    t_in_item  pending_tracks[$];         // track/wire pairs not yet accepted
    t_out_item expected_dist[$];          // predicted distances in order
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_errors = 0;
    int        n_parallel = 0;
    int        n_clipped = 0;
    int        n_cycles = 0;
    int        send_gap = 0;
    int        stall_gap = 0;
    int        hold_left = 0;
    bit        hold_done = 1'b0;

    signed_line_to_line_distance_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // distance predictor: exact wide integer arithmetic, floor square root,
    // magnitude division rounded half up, then sign and clipping
    function automatic t_out_item predict_distance(t_in_item t);
        logic signed [127:0] my, mz, cy, cz, ax, ay, az, bx, by, bz;
        logic signed [127:0] wx, wy, wz, dx, dy, dz, kx, ky, kz, num, nsq;
        logic [127:0] root, trial, mag, quo, rem, top;
        bit neg;
        t_out_item r;
        my = t.track_slope_y;  mz = t.track_slope_z;
        cy = t.track_offset_y; cz = t.track_offset_z;
        ax = t.wire_a_x; ay = t.wire_a_y; az = t.wire_a_z;
        bx = t.wire_b_x; by = t.wire_b_y; bz = t.wire_b_z;
        wx = ax - bx; wy = ay - by; wz = az - bz;
        dx = 128'sd850 * 128'sd65536 - ax;
        dy = 128'sd850 * my + cy - ay;
        dz = 128'sd850 * mz + cz - az;
        // w x v with v = (1.0, my, mz)
        kx = wy * mz - wz * my;
        ky = wz * 128'sd65536 - wx * mz;
        kz = wx * my - wy * 128'sd65536;
        num = dx * kx + dy * ky + dz * kz;
        nsq = kx * kx + ky * ky + kz * kz;
        r = '0;
        if (nsq == 0) begin
            r.lines_parallel = 1'b1;
            return r;
        end
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= nsq) root = trial;
        end
        neg = num < 0;
        mag = neg ? -num : num;
        quo = mag / root;
        rem = mag % root;
        if (rem >= root - rem) quo = quo + 1;
        top = neg ? 128'd2147483648 : 128'd2147483647;
        if (quo > top) begin
            quo = top;
            r.saturated = 1'b1;
        end
        r.distance = neg ? -quo[31:0] : quo[31:0];
        return r;
    endfunction

    function automatic t_in_item make_pair(int my, int cy, int mz, int cz,
                                           int ax, int ay, int az,
                                           int bx, int by, int bz);
        t_in_item t;
        t.track_slope_y = my[23:0]; t.track_offset_y = cy;
        t.track_slope_z = mz[23:0]; t.track_offset_z = cz;
        t.wire_a_x = ax; t.wire_a_y = ay; t.wire_a_z = az;
        t.wire_b_x = bx; t.wire_b_y = by; t.wire_b_z = bz;
        return t;
    endfunction

    // append a pair to the tail of the pending list
    function automatic void queue_pair(t_in_item t);
        pending_tracks.insert(pending_tracks.size(), t);
    endfunction

    // mostly zero, sometimes a few cycles, rarely a long gap
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // stretches of back-to-back traffic every couple of hundred transactions
    function automatic bit busy_phase();
        return (n_sent % 200) < 50;
    endfunction

    // random coordinate inside about +-1000 mm, q16.16
    function automatic int coord_mm();
        return $urandom_range(0, 131072000) - 65536000;
    endfunction

    function automatic t_in_item random_pair();
        t_in_item t;
        logic [351:0] raw;
        int kind, s, my, mz, ax, ay, az;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            // raw noise over the full field ranges
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom};
            t = raw[$bits(t_in_item)-1:0];
        end else if (kind < 30) begin
            // wire exactly parallel to the track, or collapsed to a point
            my = $urandom_range(0, 262144) - 131072;
            mz = $urandom_range(0, 262144) - 131072;
            s  = $urandom_range(0, 64) - 32;
            ax = coord_mm(); ay = coord_mm(); az = coord_mm();
            t = make_pair(my, coord_mm(), mz, coord_mm(), ax, ay, az,
                          ax - 65536 * s, ay - my * s, az - mz * s);
        end else begin
            // realistic track and a long wire mostly along z with a small stereo tilt
            my = $urandom_range(0, 262144) - 131072;
            mz = $urandom_range(0, 262144) - 131072;
            ax = coord_mm(); ay = coord_mm();
            t = make_pair(my, coord_mm(), mz, coord_mm(),
                          ax, ay, 65536000 + $urandom_range(0, 65536),
                          ax + $urandom_range(0, 6553600) - 3276800,
                          ay + $urandom_range(0, 6553600) - 3276800,
                          -65536000 - $urandom_range(0, 65536));
        end
        return t;
    endfunction

    // sender: next pair is offered when the slot is free, after any random gap or drain pause
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_dist.insert(expected_dist.size(),
                                     predict_distance(pending_tracks.pop_front()));
                n_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (n_sent == PAUSE_AT && expected_dist.size() != 0) begin
                    i_valid <= 1'b0;          // wait for the pipeline to empty
                end else if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid  <= 1'b0;
                end else if (pending_tracks.size() != 0) begin
                    i_valid  <= 1'b1;
                    i_item   <= pending_tracks[0];
                    send_gap <= busy_phase() ? 0 : idle_len();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stall, plus one long hold so the pipeline backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (!hold_done && n_sent >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall   <= 1'b0;
            stall_gap <= busy_phase() ? 0 : idle_len();
        end
    end

    // monitor: each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_dist.size() == 0) begin
                $error("result with no transaction outstanding: distance %0d", o_item.distance);
                n_errors++;
            end else begin
                want = expected_dist.pop_front();
                if (o_item.distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, o_item.distance);
                    n_errors++;
                end
                if (o_item.lines_parallel !== want.lines_parallel) begin
                    $error("lines_parallel: expected %0b, got %0b",
                           want.lines_parallel, o_item.lines_parallel);
                    n_errors++;
                end
                if (o_item.saturated !== want.saturated) begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, o_item.saturated);
                    n_errors++;
                end
                n_parallel += want.lines_parallel;
                n_clipped  += want.saturated;
                n_checked++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int big, lo;
        big = 32'h7fffffff;
        lo  = 32'h80000000;
        // directed: degenerate, parallel, textbook and extreme geometries
        queue_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_pair(make_pair(65536, 0, 0, 0, 100, 200, 300, 100, 200, 300));
        queue_pair(make_pair(65536, 5 << 16, -65536, 0,
                             0, 0, 0, -65536, -65536, 65536));
        queue_pair(make_pair(0, 0, 0, 0,
                             0, 10 << 16, 100 << 16, 0, 10 << 16, -100 << 16));
        queue_pair(make_pair(0, 0, 0, 0,
                             0, -10 << 16, 100 << 16, 0, -10 << 16, -100 << 16));
        queue_pair(make_pair(0, 3 << 16, 0, 0,
                             850 << 16, 0, 5 << 16, 850 << 16, 0, -5 << 16));
        queue_pair(make_pair(0, 1, 0, 0, 0, 0, 3, 0, 0, -3));
        queue_pair(make_pair(0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
        queue_pair(make_pair(32'h7fffff, big, 32'h7fffff, big,
                             lo, lo, lo, big, big, big));
        queue_pair(make_pair(32'h800000, lo, 32'h800000, lo,
                             big, big, big, lo, lo, lo));
        queue_pair(make_pair(32'h7fffff, lo, 32'h800000, big,
                             big, lo, 0, lo, big, 1));
        queue_pair(make_pair(0, big, 0, lo, 0, 0, 1, 0, 0, -1));
        queue_pair(make_pair(0, lo, 0, big, 0, 0, 1, 0, 0, -1));
        queue_pair(make_pair(32'h800000, 0, 32'h7fffff, 0,
                             lo, 0, 0, big, 0, 0));
        queue_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
        queue_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, 0, 0, 0));
        queue_pair(make_pair(32'h555555, 32'haaaaaaaa, 32'haaaaaa, 32'h55555555,
                             32'h55555555, 32'haaaaaaaa, 32'h55555555,
                             32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa));
        queue_pair(make_pair(131072, 7 << 16, -131072, -9 << 16,
                             65536 * 850, 3 << 16, big, 0, -3 << 16, lo));
        for (int n = 0; n < N_RANDOM; n++)
            queue_pair(random_pair());

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_tracks.size() == 0 && !i_valid);
        wait (expected_dist.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d track/wire pairs sent, %0d distances checked", n_sent, n_checked);
        $display("%0d parallel or degenerate, %0d clipped to range", n_parallel, n_clipped);
        if (n_errors == 0 && expected_dist.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/slldc_pkg.sv
rtl/slldc_sqrt.sv
rtl/slldc_div.sv
rtl/signed_line_to_line_distance_core.sv
tb/signed_line_to_line_distance_core_test.sv
